@@ rtl/lgts_pkg.sv @@
package lgts_pkg;

  // command field codes
  localparam logic [2:0] CMD_SAMPLE = 3'd0;
  localparam logic [2:0] CMD_WR_WT  = 3'd1;
  localparam logic [2:0] CMD_WR_TT  = 3'd2;
  localparam logic [2:0] CMD_WR_DT  = 3'd3;
  localparam logic [2:0] CMD_WR_AL  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_BETA     = 2'd0;
  localparam logic [1:0] CFG_SUM_BETA = 2'd1;
  localparam logic [1:0] CFG_TOPICS   = 2'd2;

  localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] W_MAX     = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_WRITE,
    OP_DEC_RD,
    OP_DEC_WR,
    OP_K_RD,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_SUM,
    OP_ACC,
    OP_SC_HI,
    OP_SC_LO,
    OP_THR,
    OP_S_RD,
    OP_S_CMP,
    OP_INC_RD,
    OP_INC_WR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_sample;
    logic is_write;
    logic div_skip;
    logic div_last;
    logic k_last;
    logic hit;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/lgts_ctrl.sv @@
module lgts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lgts_pkg::dp_status_t st_i,
  output lgts_pkg::dp_cmd_t    cmd_o
);
  import lgts_pkg::*;

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DECODE   = 5'd2;
  localparam logic [4:0] S_WRITE    = 5'd3;
  localparam logic [4:0] S_DEC_RD   = 5'd4;
  localparam logic [4:0] S_DEC_WR   = 5'd5;
  localparam logic [4:0] S_K_RD     = 5'd6;
  localparam logic [4:0] S_LOAD     = 5'd7;
  localparam logic [4:0] S_DIV_INIT = 5'd8;
  localparam logic [4:0] S_DIV      = 5'd9;
  localparam logic [4:0] S_MUL_HI   = 5'd10;
  localparam logic [4:0] S_MUL_LO   = 5'd11;
  localparam logic [4:0] S_SUM      = 5'd12;
  localparam logic [4:0] S_ACC      = 5'd13;
  localparam logic [4:0] S_SC_HI    = 5'd14;
  localparam logic [4:0] S_SC_LO    = 5'd15;
  localparam logic [4:0] S_THR      = 5'd16;
  localparam logic [4:0] S_S_RD     = 5'd17;
  localparam logic [4:0] S_S_CMP    = 5'd18;
  localparam logic [4:0] S_INC_RD   = 5'd19;
  localparam logic [4:0] S_INC_WR   = 5'd20;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (st_i.is_sample) state_d = S_DEC_RD;
        else if (st_i.is_write)      state_d = S_WRITE;
        else                         state_d = S_IDLE;
      end
      S_WRITE: begin
        cmd_o.op = OP_WRITE;
        state_d  = S_IDLE;
      end
      S_DEC_RD: begin
        cmd_o.op = OP_DEC_RD;
        state_d  = S_DEC_WR;
      end
      S_DEC_WR: begin
        cmd_o.op = OP_DEC_WR;
        state_d  = S_K_RD;
      end
      S_K_RD: begin
        cmd_o.op = OP_K_RD;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        state_d  = st_i.div_skip ? S_MUL_HI : S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (st_i.div_last) state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.op = OP_MUL_HI;
        state_d  = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.op = OP_MUL_LO;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = st_i.k_last ? S_SC_HI : S_K_RD;
      end
      S_SC_HI: begin
        cmd_o.op = OP_SC_HI;
        state_d  = S_SC_LO;
      end
      S_SC_LO: begin
        cmd_o.op = OP_SC_LO;
        state_d  = S_THR;
      end
      S_THR: begin
        cmd_o.op = OP_THR;
        state_d  = S_S_RD;
      end
      S_S_RD: begin
        cmd_o.op = OP_S_RD;
        state_d  = S_S_CMP;
      end
      S_S_CMP: begin
        cmd_o.op = OP_S_CMP;
        state_d  = st_i.hit ? S_INC_RD : S_S_RD;
      end
      S_INC_RD: begin
        cmd_o.op = OP_INC_RD;
        if (st_i.out_free) state_d = S_INC_WR;
      end
      S_INC_WR: begin
        cmd_o.op = OP_INC_WR;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/lgts_dp.sv @@
module lgts_dp #(
  parameter int MAX_TOPICS = 64,
  parameter int MAX_WORDS  = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lgts_pkg::dp_cmd_t     cmd_i,
  output lgts_pkg::dp_status_t  st_o,
  input  logic [2:0]           command_i,
  input  logic [11:0]          word_id_i,
  input  logic [5:0]           topic_i,
  input  logic [31:0]          value_i,
  input  logic [31:0]          uniform_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [5:0]           new_topic_o
);
  import lgts_pkg::*;

  localparam int TW       = $clog2(MAX_TOPICS);
  localparam int KW       = $clog2(MAX_TOPICS + 1);
  localparam int WT_DEPTH = MAX_WORDS * MAX_TOPICS;
  localparam int AW       = $clog2(WT_DEPTH);

  // configuration registers
  logic [31:0] beta_q, sum_beta_q;
  logic [6:0]  topics_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q     <= 32'd65536;
      sum_beta_q <= 32'd65536;
      topics_q   <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BETA:     beta_q     <= cfg_data_i;
        CFG_SUM_BETA: sum_beta_q <= cfg_data_i;
        CFG_TOPICS:   topics_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // transaction registers
  logic [2:0]    cmd_q;
  logic [31:0]   value_q, uni_q;
  logic [TW-1:0] tidx_q;
  logic [AW-1:0] base_q;
  logic [KW-1:0] kuse_q;
  logic          ok_q;
  int            kuse_c;

  always_comb begin
    kuse_c = int'(topics_q);
    if (kuse_c == 0) kuse_c = 1;
    if (kuse_c > MAX_TOPICS) kuse_c = MAX_TOPICS;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      cmd_q   <= command_i;
      value_q <= value_i;
      uni_q   <= uniform_i;
      tidx_q  <= TW'(topic_i);
      base_q  <= AW'(32'(word_id_i) * 32'(MAX_TOPICS));
      kuse_q  <= KW'(kuse_c);
      ok_q    <= (32'(word_id_i) < 32'(MAX_WORDS)) && (32'(topic_i) < 32'(MAX_TOPICS));
    end
  end

  // clearing pass counter
  logic [AW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.op == OP_CLEAR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // loop registers
  logic [TW-1:0] k_q, pick_q;
  logic [TW-1:0] ta;
  logic [AW-1:0] wt_addr;

  always_comb begin
    unique case (cmd_i.op)
      OP_DEC_RD, OP_DEC_WR, OP_WRITE: ta = tidx_q;
      OP_INC_RD, OP_INC_WR:           ta = pick_q;
      default:                        ta = k_q;
    endcase
  end

  assign wt_addr = base_q + AW'(ta);

  // tables
  logic [23:0] wt_mem [WT_DEPTH];
  logic [31:0] tt_mem [MAX_TOPICS];
  logic [15:0] dt_mem [MAX_TOPICS];
  logic [31:0] al_mem [MAX_TOPICS];
  logic [47:0] cw_mem [MAX_TOPICS];

  logic [23:0] wt_rd_q;
  logic [31:0] tt_rd_q, al_rd_q;
  logic [15:0] dt_rd_q;
  logic [47:0] cw_rd_q;

  logic          is_clr, tbl_clr, is_dec, is_inc, is_wr;
  logic          wt_we, tt_we, dt_we, al_we;
  logic [AW-1:0] wt_wa;
  logic [TW-1:0] tbl_wa;
  logic [23:0]   wt_wd;
  logic [31:0]   tt_wd, al_wd;
  logic [15:0]   dt_wd;
  logic [47:0]   run_q, run_new;

  assign is_clr  = (cmd_i.op == OP_CLEAR);
  assign tbl_clr = is_clr && (32'(clr_q) < 32'(MAX_TOPICS));
  assign is_dec  = (cmd_i.op == OP_DEC_WR);
  assign is_inc  = (cmd_i.op == OP_INC_WR);
  assign is_wr   = (cmd_i.op == OP_WRITE);

  assign wt_we  = is_clr || is_dec || is_inc || (is_wr && cmd_q == CMD_WR_WT);
  assign tt_we  = tbl_clr || is_dec || is_inc || (is_wr && cmd_q == CMD_WR_TT);
  assign dt_we  = tbl_clr || is_dec || is_inc || (is_wr && cmd_q == CMD_WR_DT);
  assign al_we  = tbl_clr || (is_wr && cmd_q == CMD_WR_AL);
  assign wt_wa  = is_clr ? clr_q : wt_addr;
  assign tbl_wa = is_clr ? clr_q[TW-1:0] : ta;

  // zero on clear, saturating decrement on removal, increment on add-back, else write data
  always_comb begin
    priority if (is_clr) begin
      wt_wd = '0;
      tt_wd = '0;
      dt_wd = '0;
    end else if (is_dec) begin
      wt_wd = (wt_rd_q == '0) ? '0 : wt_rd_q - 1'b1;
      tt_wd = (tt_rd_q == '0) ? '0 : tt_rd_q - 1'b1;
      dt_wd = (dt_rd_q == '0) ? '0 : dt_rd_q - 1'b1;
    end else if (is_inc) begin
      wt_wd = (wt_rd_q == '1) ? wt_rd_q : wt_rd_q + 1'b1;
      tt_wd = (tt_rd_q == '1) ? tt_rd_q : tt_rd_q + 1'b1;
      dt_wd = (dt_rd_q == '1) ? dt_rd_q : dt_rd_q + 1'b1;
    end else begin
      wt_wd = value_q[23:0];
      tt_wd = value_q;
      dt_wd = value_q[15:0];
    end
  end
  assign al_wd = is_clr ? '0 : value_q;

  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    wt_rd_q <= wt_mem[wt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tt_we) tt_mem[tbl_wa] <= tt_wd;
    tt_rd_q <= tt_mem[ta];
  end

  always_ff @(posedge clk_i) begin
    if (dt_we) dt_mem[tbl_wa] <= dt_wd;
    dt_rd_q <= dt_mem[ta];
  end

  always_ff @(posedge clk_i) begin
    if (al_we) al_mem[tbl_wa] <= al_wd;
    al_rd_q <= al_mem[ta];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACC) cw_mem[k_q] <= run_new;
    cw_rd_q <= cw_mem[k_q];
  end

  // operands: num in Q25.16, den in Q33.16, factor in Q17.16
  logic [40:0] num_q;
  logic [48:0] den_q;
  logic [32:0] fac_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      num_q <= {1'b0, wt_rd_q, 16'b0} + 41'(beta_q);
      den_q <= {1'b0, tt_rd_q, 16'b0} + 49'(sum_beta_q);
      fac_q <= {1'b0, dt_rd_q, 16'b0} + 33'(al_rd_q);
    end
  end

  // bit-serial restoring divider, one quotient bit per cycle
  logic [48:0] rem_q;
  logic [31:0] quo_q, nlo_q;
  logic [4:0]  cnt_q;
  logic        div_ovf, div_skip;
  logic [49:0] trial, diff;
  logic        ge;

  assign div_ovf  = {24'b0, num_q} >= {den_q, 16'b0};
  assign div_skip = (den_q == '0) || div_ovf;
  assign trial    = {rem_q, nlo_q[31]};
  assign diff     = trial - {1'b0, den_q};
  assign ge       = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV_INIT) begin
      cnt_q <= '0;
      rem_q <= 49'(num_q[40:16]);
      nlo_q <= {num_q[15:0], 16'b0};
      if (den_q == '0) begin
        quo_q <= (num_q == '0) ? '0 : RATIO_MAX;
      end else if (div_ovf) begin
        quo_q <= RATIO_MAX;
      end else begin
        quo_q <= '0;
      end
    end else if (cmd_i.op == OP_DIV_STEP) begin
      cnt_q <= cnt_q + 1'b1;
      rem_q <= ge ? diff[48:0] : trial[48:0];
      quo_q <= {quo_q[30:0], ge};
      nlo_q <= {nlo_q[30:0], 1'b0};
    end
  end

  // shared multiplier; the factor or the uniform is split into high and low halves for its 17-bit operand
  logic [47:0] mul_a;
  logic [16:0] mul_b;
  logic [64:0] prod;
  logic [64:0] hi_q, lo_q;
  logic [64:0] half_sum;
  logic [47:0] w_q, thr_q;
  logic [48:0] run_sum;

  always_comb begin
    unique case (cmd_i.op)
      OP_MUL_HI: begin
        mul_a = {16'b0, quo_q};
        mul_b = fac_q[32:16];
      end
      OP_MUL_LO: begin
        mul_a = {16'b0, quo_q};
        mul_b = {1'b0, fac_q[15:0]};
      end
      OP_SC_HI: begin
        mul_a = run_q;
        mul_b = {1'b0, uni_q[31:16]};
      end
      default: begin
        mul_a = run_q;
        mul_b = {1'b0, uni_q[15:0]};
      end
    endcase
  end

  assign prod     = 65'(mul_a) * 65'(mul_b);
  assign half_sum = hi_q + {16'b0, lo_q[64:16]};
  assign run_sum  = {1'b0, run_q} + {1'b0, w_q};
  assign run_new  = run_sum[48] ? W_MAX : run_sum[47:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MUL_HI || cmd_i.op == OP_SC_HI) hi_q <= prod;
    if (cmd_i.op == OP_MUL_LO || cmd_i.op == OP_SC_LO) lo_q <= prod;
    if (cmd_i.op == OP_SUM) w_q <= (half_sum[64:48] != '0) ? W_MAX : half_sum[47:0];
    if (cmd_i.op == OP_THR) thr_q <= half_sum[63:16];
  end

  logic k_last;
  assign k_last = (32'(k_q) + 32'd1) == 32'(kuse_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      pick_q <= '0;
      run_q  <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_DEC_WR: begin
          k_q   <= '0;
          run_q <= '0;
        end
        OP_ACC: begin
          k_q   <= k_q + 1'b1;
          run_q <= run_new;
        end
        OP_THR: k_q <= '0;
        OP_S_CMP: begin
          if (st_o.hit) pick_q <= k_q;
          else          k_q    <= k_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  logic       out_valid_q;
  logic [5:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_inc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_inc) out_q <= 6'(pick_q);
  end

  assign out_valid_o = out_valid_q;
  assign new_topic_o = out_q;

  assign st_o.clr_last  = (32'(clr_q) == 32'(WT_DEPTH - 1));
  assign st_o.is_sample = ok_q && (cmd_q == CMD_SAMPLE);
  assign st_o.is_write  = ok_q && (cmd_q == CMD_WR_WT || cmd_q == CMD_WR_TT ||
                                   cmd_q == CMD_WR_DT || cmd_q == CMD_WR_AL);
  assign st_o.div_skip  = div_skip;
  assign st_o.div_last  = (cnt_q == 5'd31);
  assign st_o.k_last    = k_last;
  assign st_o.hit       = (cw_rd_q >= thr_q) || k_last;
  assign st_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

@@ rtl/lda_gibbs_token_sampler_top.sv @@
// Sample transaction: decrement the token's counts, then for each of the K topics in use
// form its weight and running sum, scale the total by the uniform, scan for the picked
// topic P and add it back, waiting for a stalled output. Each topic's weight uses the
// bit-serial divider, which a zero denominator or overflowing quotient skips. One transaction
// in flight at a time. After reset a clearing pass zeroes the count tables and the alpha
// table with input stalled until it ends. Configuration registers reset to 1.0, 1.0 and 64.
module lda_gibbs_token_sampler_top #(
  parameter int MAX_TOPICS = 64,
  parameter int MAX_WORDS  = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [11:0] word_id_i,
  input  logic [5:0]  topic_i,
  input  logic [31:0] value_i,
  input  logic [31:0] uniform_i,
  input  logic        last_token_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  new_topic_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import lgts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  lgts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  lgts_dp #(
    .MAX_TOPICS (MAX_TOPICS),
    .MAX_WORDS  (MAX_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .command_i   (command_i),
    .word_id_i   (word_id_i),
    .topic_i     (topic_i),
    .value_i     (value_i),
    .uniform_i   (uniform_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .new_topic_o (new_topic_o)
  );

endmodule
